[rtl/word_hash_mod_prime_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the word hash core
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WORD_HASH_MOD_PRIME_CORE_ASSERT_SVH
`define WORD_HASH_MOD_PRIME_CORE_ASSERT_SVH

`ifndef SYNTH

`define WHMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("whmp: same-cycle check failed");

`define WHMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("whmp: next-cycle check failed");

`else

`define WHMP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define WHMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/whmp_pkg.sv]
// ----------------------------------------------------------------------------
// whmp_pkg
// Shared types, constants and the character code table of the word hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package whmp_pkg;

	localparam int HASH_WIDTH_DEFAULT = 27;
	localparam int MAX_CHARS_DEFAULT  = 30;
	localparam int CMD_DEPTH          = 2;

	localparam logic [63:0] MODULUS_RESET = 64'd134217689;

	localparam logic [7:0] NO_CODE = 8'hFF;
	localparam logic [6:0] CHAR_BASE = 7'd32;

	// Printable characters (code point minus the base) to 6-bit codes.
	localparam logic [7:0] CODE_TABLE [0:95] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0,  8'd31,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'd2,  8'd25, 8'd20, 8'd35, 8'd54, 8'd61, 8'd40, 8'd39,
		8'd42, 8'd33, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'd60, 8'd43, 8'd30, 8'd5,  8'd16, 8'd47, 8'd18,
		8'd41, 8'd36, 8'd51, 8'd6,  8'd13, 8'd56, 8'd55, 8'd58,
		8'd49, 8'd12, 8'd59, 8'd46, 8'd21, 8'd32, 8'd63, 8'd34,
		8'd57, 8'd52, 8'd3,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'd22, 8'd29, 8'd8,  8'd7,  8'd10, 8'd1,  8'd28,
		8'd11, 8'd62, 8'd37, 8'd48, 8'd15, 8'd50, 8'd9,  8'd4,
		8'd19, 8'd38, 8'd45, 8'd24, 8'd23, 8'd26, 8'd17, 8'd44,
		8'd27, 8'd14, 8'd53, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct packed {
		logic       valid;
		logic [5:0] code;
	} code_t;

	// One command from the front end to the arithmetic back end.
	typedef struct packed {
		logic       is_end;
		logic       trash;
		logic       last;
		logic [5:0] code;
	} cmd_t;

	function automatic code_t code_lookup(input logic [6:0] c);
		logic [6:0] idx;
		logic [7:0] entry;
		code_t      r;
		idx   = c - CHAR_BASE;
		entry = CODE_TABLE[idx];
		r.valid = (c >= CHAR_BASE) && (entry != NO_CODE);
		r.code  = entry[5:0];
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/whmp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// whmp_cmd_fifo
// Small command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module whmp_cmd_fifo #(
	parameter int DEPTH = whmp_pkg::CMD_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  whmp_pkg::cmd_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output whmp_pkg::cmd_t  rd_data,
	output logic            empty
);
	import whmp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[rtl/whmp_front.sv]
// ----------------------------------------------------------------------------
// whmp_front
// Takes bytes, classifies them and tracks length and validity of the word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_hash_mod_prime_core_assert.svh"

module whmp_front #(
	parameter int MAX_CHARS = whmp_pkg::MAX_CHARS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      character,
	output logic            full,
	input  logic            q_full,
	output logic            q_push,
	output whmp_pkg::cmd_t  q_data
);
	import whmp_pkg::*;

	localparam int CW = $clog2(MAX_CHARS + 1);

	logic [CW-1:0] count_q;
	logic          trash_q;
	logic          accept;
	logic [6:0]    c7;
	logic          is_end;
	logic          is_bad;
	code_t         lk;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign c7     = character[6:0];
	assign is_end = (c7 == '0);
	assign lk     = code_lookup(c7);
	assign is_bad = !lk.valid || (count_q >= CW'(MAX_CHARS));

	// Characters after a bad one are dropped until the word ends.
	assign q_push = accept && (is_end || (!trash_q && !is_bad));

	always_comb begin
		q_data.is_end = is_end;
		q_data.trash  = trash_q;
		q_data.last   = (count_q == CW'(MAX_CHARS - 1));
		q_data.code   = lk.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trash_q <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				count_q <= '0;
				trash_q <= 1'b0;
			end else if (!trash_q) begin
				if (is_bad) begin
					trash_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	`WHMP_ASSERT_IMP(a_trash_drops, clk, arst_n, trash_q && accept && !is_end, !q_push)
	`WHMP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_CHARS))

endmodule

`default_nettype wire

[rtl/whmp_back.sv]
// ----------------------------------------------------------------------------
// whmp_back
// Runs the modular arithmetic of each command with compare-subtract steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_hash_mod_prime_core_assert.svh"

module whmp_back #(
	parameter int HASH_WIDTH = whmp_pkg::HASH_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [HASH_WIDTH-1:0] modulus,
	input  whmp_pkg::cmd_t        cmd,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [HASH_WIDTH-1:0] res_hash,
	output logic                  res_unhashable
);
	import whmp_pkg::*;

	localparam int TW = HASH_WIDTH + 4;
	localparam int BW = $clog2(HASH_WIDTH);
	localparam logic [HASH_WIDTH-1:0] FIRST_WEIGHT = HASH_WIDTH'(1) << (HASH_WIDTH - 8);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PRE  = 7'b0000010,
		ST_LOAD = 7'b0000100,
		ST_W2   = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_RED  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [HASH_WIDTH-1:0] acc_q;
	logic [HASH_WIDTH-1:0] wgt_q;
	logic [TW-1:0]         ta_q;
	logic [TW-1:0]         tb_q;
	logic [BW-1:0]         bit_q;
	logic [1:0]            step_q;

	logic [HASH_WIDTH:0]   m_eff;
	logic [TW-1:0]         m_sh;
	logic [TW-1:0]         ta_red;
	logic [TW-1:0]         tb_red;
	logic [HASH_WIDTH:0]   ra_sh;
	logic [HASH_WIDTH:0]   rb_sh;
	logic [HASH_WIDTH:0]   ra_new;
	logic [HASH_WIDTH:0]   rb_new;
	logic                  need_pre;
	logic [TW-1:0]         sum;
	logic [HASH_WIDTH-1:0] w2;

	// A zero modulus register stands for two to the hash width.
	assign m_eff = {modulus == '0, modulus};
	assign m_sh  = TW'(m_eff) << step_q;

	assign ta_red = (ta_q >= m_sh) ? ta_q - m_sh : ta_q;
	assign tb_red = (tb_q >= m_sh) ? tb_q - m_sh : tb_q;

	// Restoring remainder, one bit of accumulator and weight per cycle.
	assign ra_sh  = {ta_q[HASH_WIDTH-1:0], acc_q[bit_q]};
	assign rb_sh  = {tb_q[HASH_WIDTH-1:0], wgt_q[bit_q]};
	assign ra_new = (ra_sh >= m_eff) ? ra_sh - m_eff : ra_sh;
	assign rb_new = (rb_sh >= m_eff) ? rb_sh - m_eff : rb_sh;

	assign need_pre = ({1'b0, acc_q} >= m_eff) || ({1'b0, wgt_q} >= m_eff);

	assign w2  = ta_q[HASH_WIDTH-1:0];
	assign sum = TW'(acc_q) + TW'(wgt_q) * TW'(cmd_q.code[2:0])
		+ TW'(w2) * TW'(cmd_q.code[5:3]);

	assign cmd_pop        = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid      = (state_q == ST_OUT);
	assign res_hash       = cmd_q.trash ? '1 : acc_q;
	assign res_unhashable = cmd_q.trash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			acc_q   <= '0;
			wgt_q   <= FIRST_WEIGHT;
			ta_q    <= '0;
			tb_q    <= '0;
			bit_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						if (cmd.is_end && cmd.trash) begin
							state_q <= ST_OUT;
						end else if (need_pre) begin
							ta_q    <= '0;
							tb_q    <= '0;
							bit_q   <= BW'(HASH_WIDTH - 1);
							state_q <= ST_PRE;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PRE: begin
					ta_q  <= TW'(ra_new[HASH_WIDTH-1:0]);
					tb_q  <= TW'(rb_new[HASH_WIDTH-1:0]);
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						acc_q   <= ra_new[HASH_WIDTH-1:0];
						wgt_q   <= rb_new[HASH_WIDTH-1:0];
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cmd_q.is_end) begin
						state_q <= ST_OUT;
					end else begin
						ta_q    <= TW'(wgt_q) << 3;
						step_q  <= 2'd3;
						state_q <= ST_W2;
					end
				end
				ST_W2: begin
					step_q <= step_q - 2'd1;
					if (step_q == '0) begin
						// The last allowed character gives its high half no weight.
						ta_q    <= cmd_q.last ? '0 : ta_red;
						state_q <= ST_SUM;
					end else begin
						ta_q <= ta_red;
					end
				end
				ST_SUM: begin
					tb_q    <= sum;
					ta_q    <= TW'(w2) << 3;
					step_q  <= 2'd3;
					state_q <= ST_RED;
				end
				ST_RED: begin
					ta_q   <= ta_red;
					tb_q   <= tb_red;
					step_q <= step_q - 2'd1;
					if (step_q == '0) begin
						acc_q   <= tb_red[HASH_WIDTH-1:0];
						wgt_q   <= ta_red[HASH_WIDTH-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						acc_q   <= '0;
						wgt_q   <= FIRST_WEIGHT;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`WHMP_ASSERT_NEXT(a_out_clears, clk, arst_n, res_valid && res_ready,
		state_q == ST_IDLE && acc_q == '0 && wgt_q == FIRST_WEIGHT)
	`WHMP_ASSERT_IMP(a_sum_after_w2, clk, arst_n, state_q == ST_SUM,
		$past(state_q == ST_W2))

endmodule

`default_nettype wire

[rtl/word_hash_mod_prime_core.sv]
// A character passes through the arithmetic back end as queue pop, setup,
// four compare-subtract steps for the next weight, one sum and four reduction steps.
// An ending byte goes from the queue pop through setup (skipped when poisoned) to output;
// a bitwise pre-reduction runs first if a modulus change left stored values not below it.
// Bytes are taken every cycle while the 2-entry command queue has room.
// Reset (arst_n low) clears the word state at once and loads the reset modulus.
// ----------------------------------------------------------------------------
// word_hash_mod_prime_core
// Modular polynomial hash of a byte stream, one hash word per ending byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_hash_mod_prime_core_assert.svh"

module word_hash_mod_prime_core #(
	parameter int HASH_WIDTH = whmp_pkg::HASH_WIDTH_DEFAULT,
	parameter int MAX_CHARS  = whmp_pkg::MAX_CHARS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  modulus_we,
	input  logic [HASH_WIDTH-1:0] modulus_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            character,
	output logic                  empty,
	input  logic                  pop,
	output logic [HASH_WIDTH-1:0] hash_value,
	output logic                  unhashable
);
	import whmp_pkg::*;

	logic [HASH_WIDTH-1:0] modulus_q;
	logic                  q_full;
	logic                  q_push;
	cmd_t                  q_wdata;
	cmd_t                  q_rdata;
	logic                  q_empty;
	logic                  q_pop;
	logic                  res_valid;
	logic                  res_ready;
	logic [HASH_WIDTH-1:0] res_hash;
	logic                  res_unhashable;
	logic                  out_valid_q;
	logic [HASH_WIDTH-1:0] hash_q;
	logic                  unh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET[HASH_WIDTH-1:0];
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	whmp_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.character(character),
		.full     (full),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	whmp_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	whmp_back #(
		.HASH_WIDTH(HASH_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus       (modulus_q),
		.cmd           (q_rdata),
		.cmd_valid     (!q_empty),
		.cmd_pop       (q_pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_hash      (res_hash),
		.res_unhashable(res_unhashable)
	);

	// Output word register; it refills in the same cycle it is popped.
	assign res_ready  = !out_valid_q || pop;
	assign empty      = !out_valid_q;
	assign hash_value = hash_q;
	assign unhashable = unh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hash_q      <= '0;
			unh_q       <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				hash_q      <= res_hash;
				unh_q       <= res_unhashable;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WHMP_ASSERT_NEXT(a_out_loaded, clk, arst_n, res_valid && res_ready, out_valid_q)

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for word_hash_mod_prime_core. Bytes go in through the
// push side, and each finished word's hash is compared against a local
// predictor of the hash. Directed tests cover empty words, bad characters,
// length limits and modulus extremes. Random words then run under several
// modulus settings, with idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import whmp_pkg::*;

	localparam int HW   = HASH_WIDTH_DEFAULT;
	localparam int MAXC = MAX_CHARS_DEFAULT;

	localparam logic [7:0]    END_BYTE     = 8'h00;
	localparam logic [7:0]    END_BYTE_HI  = 8'h80;
	localparam logic [7:0]    UNMAPPED     = 8'hFF;
	localparam logic [HW-1:0] MOD_RESET    = 27'd134217689;
	localparam logic [HW-1:0] MOD_MIN      = 27'd524289;
	localparam logic [HW-1:0] MOD_MAX      = '1;
	localparam logic [63:0]   FIRST_WEIGHT = 64'd1 << (HW - 8);
	localparam int            SETTLE       = 120;
	localparam int            RX_HOLD      = 400;
	localparam int            LIMIT        = 500000;

	// Printable characters (code point minus 32) to 6-bit codes.
	localparam logic [7:0] CHAR_CODE [0:95] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0,  8'd31,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'd2,  8'd25, 8'd20, 8'd35, 8'd54, 8'd61, 8'd40, 8'd39,
		8'd42, 8'd33, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'd60, 8'd43, 8'd30, 8'd5,  8'd16, 8'd47, 8'd18,
		8'd41, 8'd36, 8'd51, 8'd6,  8'd13, 8'd56, 8'd55, 8'd58,
		8'd49, 8'd12, 8'd59, 8'd46, 8'd21, 8'd32, 8'd63, 8'd34,
		8'd57, 8'd52, 8'd3,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'd22, 8'd29, 8'd8,  8'd7,  8'd10, 8'd1,  8'd28,
		8'd11, 8'd62, 8'd37, 8'd48, 8'd15, 8'd50, 8'd9,  8'd4,
		8'd19, 8'd38, 8'd45, 8'd24, 8'd23, 8'd26, 8'd17, 8'd44,
		8'd27, 8'd14, 8'd53, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct packed {
		logic [HW-1:0] hash;
		logic          flag;
	} hash_word_t;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          modulus_we    = 1'b0;
	logic [HW-1:0] modulus_wdata = '0;
	logic          push          = 1'b0;
	logic [7:0]    character     = '0;
	logic          pop           = 1'b0;
	logic          full;
	logic          empty;
	logic [HW-1:0] hash_value;
	logic          unhashable;

	// Predictor state of the word being hashed.
	logic [63:0] mod_now    = MOD_RESET;
	logic [63:0] acc_now    = '0;
	logic [63:0] weight_now = FIRST_WEIGHT;
	int unsigned chars_now  = 0;
	bit          trash_now  = 1'b0;

	hash_word_t pending_hashes [$];
	int         errors     = 0;
	int         chars_sent = 0;
	int         cycles     = 0;
	int         rx_hold    = 0;
	bit         tx_idle_on = 1'b1;
	bit         rx_idle_on = 1'b1;

	word_hash_mod_prime_core #(
		.HASH_WIDTH(HW),
		.MAX_CHARS(MAXC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.modulus_we(modulus_we),
		.modulus_wdata(modulus_wdata),
		.push(push),
		.full(full),
		.character(character),
		.empty(empty),
		.pop(pop),
		.hash_value(hash_value),
		.unhashable(unhashable)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Advances the predictor by one byte; returns 1 when the byte ends a word.
	function automatic bit hash_char(input logic [7:0] ch, output hash_word_t res);
		logic [6:0]  c;
		logic [7:0]  code;
		logic [63:0] m, w1, w2, sum;
		c = ch[6:0];
		m = (mod_now == 0) ? (64'd1 << HW) : mod_now;
		res = '0;
		if (c == 0) begin
			res.hash = trash_now ? '1 : HW'(acc_now % m);
			res.flag = trash_now;
			acc_now = '0;
			weight_now = FIRST_WEIGHT;
			chars_now = 0;
			trash_now = 1'b0;
			return 1'b1;
		end
		if (trash_now)
			return 1'b0;
		code = (c >= 7'd32) ? CHAR_CODE[c - 7'd32] : UNMAPPED;
		if (code == UNMAPPED || chars_now >= MAXC) begin
			trash_now = 1'b1;
			return 1'b0;
		end
		w1 = weight_now % m;
		// The high half of the last allowed character carries no weight.
		w2 = (chars_now + 1 == MAXC) ? 64'd0 : (w1 * 8) % m;
		sum = (acc_now % m + (w1 * code[2:0]) % m) % m;
		sum = (sum + (w2 * code[5:3]) % m) % m;
		acc_now = sum;
		weight_now = (w2 * 8) % m;
		chars_now++;
		return 1'b0;
	endfunction

	function automatic logic [7:0] random_printable();
		logic [6:0] c;
		c = 7'd0;
		while (c < 7'd32 || CHAR_CODE[c - 7'd32] == UNMAPPED)
			c = 7'($urandom_range(32, 127));
		return {1'($urandom_range(1)), c};
	endfunction

	function automatic logic [7:0] random_bad_char();
		logic [6:0] c;
		c = 7'd32 + 7'd33;
		while (c >= 7'd32 && CHAR_CODE[c - 7'd32] != UNMAPPED)
			c = 7'($urandom_range(1, 127));
		return {1'($urandom_range(1)), c};
	endfunction

	function automatic logic [7:0] random_end_byte();
		return $urandom_range(1) ? END_BYTE_HI : END_BYTE;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_word();
		hash_word_t want;
		if (pending_hashes.size() == 0) begin
			report_mismatch("word with no hash pending", hash_value, '0);
			return;
		end
		want = pending_hashes.pop_front();
		if (hash_value !== want.hash)
			report_mismatch("hash_value", hash_value, want.hash);
		if (unhashable !== want.flag)
			report_mismatch("unhashable", unhashable, want.flag);
	endtask

	// Receiver: checks each popped word and decides pop for the next edge.
	always @(posedge clk) begin
		if (pop === 1'b1 && empty === 1'b0)
			check_word();
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			pop <= !rx_idle_on || ($urandom_range(99) >= 23);
		end
	end

	task automatic push_char(input logic [7:0] ch);
		hash_word_t res;
		while (tx_idle_on && $urandom_range(99) < 23) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		character <= ch;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		if (hash_char(ch, res))
			pending_hashes.push_back(res);
		chars_sent++;
	endtask

	// Stops sending until every pending hash has arrived and the core is quiet.
	task automatic drain_words();
		push <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [HW-1:0] value);
		drain_words();
		modulus_we <= 1'b1;
		modulus_wdata <= value;
		@(posedge clk);
		modulus_we <= 1'b0;
		mod_now = value;
	endtask

	task automatic send_clean_word(input int len);
		for (int i = 0; i < len; i++)
			push_char(random_printable());
		push_char(random_end_byte());
	endtask

	task automatic send_random_word();
		int         kind, len, bad_at;
		logic [7:0] ch;
		kind = $urandom_range(99);
		len = $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(0, MAXC);
		bad_at = -1;
		if (kind >= 93)
			len = $urandom_range(MAXC + 1, MAXC + 4);
		if (kind >= 78 && kind < 90) begin
			if (len == 0)
				len = 1;
			bad_at = $urandom_range(0, len - 1);
		end
		for (int i = 0; i < len; i++) begin
			if (kind >= 90 && kind < 93)
				ch = 8'($urandom_range(255));
			else if (i == bad_at)
				ch = random_bad_char();
			else
				ch = random_printable();
			push_char(ch);
		end
		push_char(random_end_byte());
	endtask

	task automatic test_basic_words();
		push_char(END_BYTE);
		push_char(END_BYTE_HI);
		push_char(8'h26);
		push_char(8'hFA);
		push_char(END_BYTE);
		push_char(8'h27);
		push_char(8'hC1);
		push_char(8'h7A);
		push_char(END_BYTE_HI);
	endtask

	task automatic test_bad_characters();
		// A control byte poisons the word; what follows it is ignored.
		push_char(8'h01);
		push_char(8'h41);
		push_char(END_BYTE);
		push_char(8'h1F);
		push_char(END_BYTE_HI);
		push_char(8'h3B);
		push_char(8'h42);
		push_char(END_BYTE);
		push_char(8'h7F);
		push_char(END_BYTE);
		push_char(8'hFF);
		push_char(END_BYTE);
		push_char(8'h20);
		push_char(8'hE0);
		push_char(END_BYTE_HI);
	endtask

	task automatic test_word_length();
		send_clean_word(MAXC);
		send_clean_word(MAXC + 1);
		send_clean_word(MAXC - 1);
	endtask

	task automatic test_modulus_extremes();
		logic [HW-1:0] mods [4];
		mods[0] = '0;
		mods[1] = 27'd1;
		mods[2] = MOD_MAX;
		mods[3] = MOD_MIN;
		for (int k = 0; k < 4; k++) begin
			write_modulus(mods[k]);
			send_clean_word(MAXC);
			repeat (3) send_clean_word($urandom_range(0, 8));
		end
		write_modulus(MOD_RESET);
	endtask

	task automatic test_modulus_mid_word();
		// Weight and sum built under the large modulus exceed the new one.
		repeat (10) push_char(random_printable());
		write_modulus(MOD_MIN);
		repeat (10) push_char(random_printable());
		push_char(END_BYTE);
		repeat (5) push_char(random_printable());
		write_modulus('0);
		repeat (5) push_char(random_printable());
		write_modulus(27'd1000003);
		repeat (8) push_char(random_printable());
		push_char(END_BYTE_HI);
	endtask

	task automatic test_backpressure();
		rx_hold = RX_HOLD;
		repeat (40) send_clean_word($urandom_range(0, 2));
		drain_words();
	endtask

	task automatic test_random_words();
		int target;
		for (int phase = 0; phase < 5; phase++) begin
			if (phase == 1)
				write_modulus(HW'($urandom()));
			else
				write_modulus(HW'($urandom_range(MOD_MIN, MOD_MAX)));
			// One phase runs with both sides always ready.
			tx_idle_on = (phase != 2);
			rx_idle_on = (phase != 2);
			target = chars_sent + 135;
			while (chars_sent < target)
				send_random_word();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_words();
		test_bad_characters();
		test_word_length();
		test_modulus_extremes();
		test_modulus_mid_word();
		test_backpressure();
		test_random_words();
		drain_words();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/whmp_pkg.sv
rtl/whmp_cmd_fifo.sv
rtl/whmp_front.sv
rtl/whmp_back.sv
rtl/word_hash_mod_prime_core.sv
tb/sv/tb_top.sv
